>>> src/lswr_pkg.sv
`default_nettype none

package lswr_pkg;

    localparam int IDX_W    = 10;
    localparam int COLOUR_W = 32;
    localparam int FRAC_W   = 17;
    localparam int LEN_W    = 11;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = 29;
    localparam int QUO_W    = 11;

    localparam logic [COLOUR_W-1:0] BLACK_ARGB = 32'hFF00_0000;
    localparam logic [FRAC_W-1:0]   Q16_ONE    = 17'h1_0000;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_REMAP_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_START    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_END      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_START    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_END      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LENGTH = 3'd5;

    localparam logic [3:0] EDGE_LAST = 4'd4;
    localparam logic [3:0] DIV_LAST  = 4'd10;

    typedef struct packed {
        logic                opcode;
        logic [IDX_W-1:0]    pixel_index;
        logic [COLOUR_W-1:0] pixel_colour;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]    out_index;
        logic [COLOUR_W-1:0] out_colour;
    } t_out;

    typedef enum logic [1:0] {
        AR_NOP      = 2'd0,
        AR_MUL      = 2'd1,
        AR_DIV_INIT = 2'd2,
        AR_DIV_STEP = 2'd3
    } t_arith_op;

    typedef struct packed {
        t_arith_op   op;
        logic [16:0] a;
        logic [11:0] b;
    } t_arith_cmd;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic [QUO_W-1:0]  quo;
    } t_arith_res;

endpackage

`default_nettype wire

>>> src/lswr_line_store.sv
`default_nettype none

module lswr_line_store #(
    parameter int Depth = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [31:0]              i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [31:0]              o_rdata
);

    logic [31:0] r_mem [Depth];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/lswr_arith.sv
`default_nettype none

module lswr_arith (
    input  wire logic                i_clk,
    input  wire lswr_pkg::t_arith_cmd i_cmd,
    output lswr_pkg::t_arith_res     o_res
);
    import lswr_pkg::*;

    logic [PROD_W-1:0] r_prod, n_prod;
    logic [10:0]       r_rem, n_rem;
    logic [10:0]       r_lo, n_lo;
    logic [10:0]       r_den, n_den;
    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [11:0]       w_trial;
    logic [11:0]       w_diff;
    logic              w_ge;

    // one restoring step: bring down the next numerator bit, subtract if it fits
    assign w_trial = {r_rem, r_lo[10]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_comb begin
        n_prod = r_prod;
        n_rem  = r_rem;
        n_lo   = r_lo;
        n_den  = r_den;
        n_quo  = r_quo;
        unique case (i_cmd.op)
            AR_MUL: begin
                n_prod = {12'd0, i_cmd.a} * {17'd0, i_cmd.b};
            end
            AR_DIV_INIT: begin
                // quotient fits 11 bits, so the upper half is already below the divisor
                n_rem = r_prod[21:11];
                n_lo  = r_prod[10:0];
                n_den = i_cmd.a[10:0];
                n_quo = '0;
            end
            AR_DIV_STEP: begin
                n_rem = w_ge ? w_diff[10:0] : w_trial[10:0];
                n_lo  = {r_lo[9:0], 1'b0};
                n_quo = {r_quo[QUO_W-2:0], w_ge};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_lo   <= n_lo;
        r_den  <= n_den;
        r_quo  <= n_quo;
    end

    assign o_res.prod = r_prod;
    assign o_res.quo  = r_quo;

endmodule

`default_nettype wire

>>> src/led_strip_window_remap_top.sv
`default_nettype none

// Read: busy stays high from an accepted start until the result strobe, in stretch mode, in
// crop mode and outside the target window alike.
// The four window edges share one multiplier, then in stretch mode one product and an
// 11-step restoring divide give the source index. Writes do not raise busy.
// Results cannot be stalled; a new start is taken in the cycle the strobe shows.
// Synchronous active-low reset clears control and configuration; the line store is not cleared.
module led_strip_window_remap_top #(
    parameter int MAX_LEDS = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire lswr_pkg::t_in        i_item,
    output logic                      o_strobe,
    output lswr_pkg::t_out            o_result,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [16:0]          i_cfg_data
);
    import lswr_pkg::*;

    localparam int AW = $clog2(MAX_LEDS);
    localparam int ResCap = (MAX_LEDS > 2047) ? 2047 : MAX_LEDS;
    localparam logic [LEN_W-1:0] RES_CAP = LEN_W'(ResCap);
    localparam logic [16:0] MAX_LEDS_W = 17'(MAX_LEDS);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b000_0001,
        ST_EDGE  = 7'b000_0010,
        ST_CHECK = 7'b000_0100,
        ST_NUM   = 7'b000_1000,
        ST_DIV   = 7'b001_0000,
        ST_FETCH = 7'b010_0000,
        ST_READ  = 7'b100_0000
    } t_state;

    t_state              r_state, n_state;
    logic [3:0]          r_cnt, n_cnt;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [LEN_W-1:0]    r_res, n_res;
    logic [10:0]         r_edge [4];
    logic [10:0]         n_edge [4];
    logic                r_strobe, n_strobe;
    t_out                r_out, n_out;

    logic                r_mode;
    logic [FRAC_W-1:0]   r_frac [4];
    logic [LEN_W-1:0]    r_strip;

    t_arith_cmd          w_cmd;
    t_arith_res          w_ares;
    logic [31:0]         w_rdata;
    logic                w_accept;
    logic                w_we;
    logic                w_re;
    logic [31:0]         w_waddr32;
    logic [31:0]         w_raddr32;
    logic [FRAC_W-1:0]   w_frac_sat;
    logic [1:0]          w_cap_idx;
    logic [11:0]         w_ss1;
    logic [11:0]         w_se;
    logic [LEN_W-1:0]    w_idx_ext;
    logic                w_in_win;
    logic [11:0]         w_src;
    logic [LEN_W-1:0]    w_len_cap;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != ST_IDLE);
    assign w_accept    = start && !busy;

    // configuration registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_frac[0] <= 17'd0;
            r_frac[1] <= Q16_ONE;
            r_frac[2] <= 17'd0;
            r_frac[3] <= 17'h0_8000;
            r_strip   <= 11'd32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_REMAP_MODE:   r_mode    <= i_cfg_data[0];
                CFG_SRC_START:    r_frac[0] <= i_cfg_data;
                CFG_SRC_END:      r_frac[1] <= i_cfg_data;
                CFG_TGT_START:    r_frac[2] <= i_cfg_data;
                CFG_TGT_END:      r_frac[3] <= i_cfg_data;
                CFG_STRIP_LENGTH: r_strip   <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // store writes within MAX_LEDS go straight through on acceptance
    assign w_we      = w_accept && (i_item.opcode == OP_WRITE) &&
                       ({7'd0, i_item.pixel_index} < MAX_LEDS_W);
    assign w_waddr32 = 32'(i_item.pixel_index);
    assign w_raddr32 = 32'(w_src);

    lswr_line_store #(
        .Depth(MAX_LEDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr32[AW-1:0]),
        .i_wdata (i_item.pixel_colour),
        .i_re    (w_re),
        .i_raddr (w_raddr32[AW-1:0]),
        .o_rdata (w_rdata)
    );

    lswr_arith u_arith (
        .i_clk (i_clk),
        .i_cmd (w_cmd),
        .o_res (w_ares)
    );

    assign w_frac_sat = (r_frac[r_cnt[1:0]] > Q16_ONE) ? Q16_ONE : r_frac[r_cnt[1:0]];
    assign w_cap_idx  = 2'(r_cnt - 4'd1);
    assign w_ss1      = {1'b0, r_edge[0]} + 12'd1;
    assign w_se       = ({1'b0, r_edge[1]} < w_ss1) ? w_ss1 : {1'b0, r_edge[1]};
    assign w_idx_ext  = {1'b0, r_idx};
    assign w_in_win   = (w_idx_ext < r_res) && (w_idx_ext >= r_edge[2]) &&
                        (w_idx_ext < r_edge[3]);
    assign w_src      = r_mode ? {2'd0, r_idx} : ({1'b0, r_edge[0]} + {1'b0, w_ares.quo});
    assign w_len_cap  = (r_strip > RES_CAP) ? RES_CAP : r_strip;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_res    = r_res;
        n_edge   = r_edge;
        n_strobe = 1'b0;
        n_out    = r_out;
        w_cmd    = '{op: AR_NOP, a: '0, b: '0};
        w_re     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_item.opcode == OP_READ)) begin
                    n_idx   = i_item.pixel_index;
                    n_res   = w_len_cap;
                    n_cnt   = '0;
                    n_state = ST_EDGE;
                end
            end
            ST_EDGE: begin
                // issue one edge product per cycle, capture the previous one
                if (r_cnt != EDGE_LAST) begin
                    w_cmd = '{op: AR_MUL, a: w_frac_sat, b: {1'b0, r_res}};
                end
                if (r_cnt != 4'd0) begin
                    n_edge[w_cap_idx] = w_ares.prod[26:16];
                end
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == EDGE_LAST) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_out.out_index = r_idx;
                if (!w_in_win) begin
                    n_out.out_colour = BLACK_ARGB;
                    n_strobe         = 1'b1;
                    n_state          = ST_IDLE;
                end else if (r_mode) begin
                    n_state = ST_FETCH;
                end else begin
                    w_cmd = '{op: AR_MUL,
                              a: 17'(w_se - {1'b0, r_edge[0]}),
                              b: 12'(w_idx_ext - r_edge[2])};
                    n_state = ST_NUM;
                end
            end
            ST_NUM: begin
                w_cmd   = '{op: AR_DIV_INIT, a: 17'(r_edge[3] - r_edge[2]), b: '0};
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                w_cmd = '{op: AR_DIV_STEP, a: '0, b: '0};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (w_src < {1'b0, r_res}) begin
                    w_re    = 1'b1;
                    n_state = ST_READ;
                end else begin
                    n_out.out_colour = '0;
                    n_strobe         = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_READ: begin
                n_out.out_colour = w_rdata;
                n_strobe         = 1'b1;
                n_state          = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_res  <= n_res;
        r_edge <= n_edge;
        r_out  <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

`default_nettype wire

>>> src/lswr_checker.sv
`default_nettype none

module lswr_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire lswr_pkg::t_in i_item,
    input wire logic          o_strobe
);
    import lswr_pkg::*;

    // a read keeps the block occupied
    a_read_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.opcode == OP_READ)) |=> busy)
        else $error("read transaction did not raise busy");

    // a write completes in the accepting cycle
    a_write_stays_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.opcode == OP_WRITE)) |=> !busy)
        else $error("write transaction raised busy");

    // every result closes a busy period
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a pending read");

    // every read passes through the edge states before its result, so results never come back to back
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in consecutive cycles");

endmodule

bind led_strip_window_remap_top lswr_checker u_lswr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe)
);

`default_nettype wire
